// ===== rtl/bdcl_pkg.sv =====
// Shared types and constants for the button debouncer with click and long press.
`default_nettype none
package bdcl_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_INPUT       = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_TICKS   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_EVENT_ENABLE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK_EVENT_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK_TAG          = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_TAG           = 3'd6;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;

  // Operation codes
  localparam logic OP_TICK        = 1'b0;
  localparam logic OP_WRITE_TOGGLE = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic        invert_input;
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic        long_event_enable;
    logic        click_event_enable;
    logic [7:0]  click_tag;
    logic [7:0]  long_tag;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] event_tag;
    logic       is_pressed;
    logic       toggle_value;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/bdcl_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface bdcl_in_if;
  logic valid;
  logic ready;
  logic op;
  logic raw_level;
  logic new_value;

  modport source (output valid, output op, output raw_level, output new_value, input ready);
  modport sink (input valid, input op, input raw_level, input new_value, output ready);
endinterface

interface bdcl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] event_tag;
  logic       is_pressed;
  logic       toggle_value;

  modport source (output valid, output event_kind, output event_tag, output is_pressed,
                  output toggle_value, input ready);
  modport sink (input valid, input event_kind, input event_tag, input is_pressed,
                input toggle_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/button_debounce_click_longpress.sv =====
// Top level: config registers, input stage, debounce core and result register.
// An accepted word passes through the input stage and then the result register before it shows on out_ch.
// Throughput: one word per cycle; the input stage advances whenever the result register
// is empty or being taken, so the input stalls only while both stages hold a word.
// Reset (rst, synchronous, active high) clears all debounce state, empties both stages
// and restores the registers to their defaults (debounce 20, long press 2000, rest 0).
`default_nettype none
module button_debounce_click_longpress
  import bdcl_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  wr_data,
  bdcl_in_if.sink                         in_ch,
  bdcl_out_if.source                      out_ch
);

  cfg_t    cfg;
  result_t res;

  logic    s1_valid;
  logic    s1_op;
  logic    s1_raw_level;
  logic    s1_new_value;
  logic    s1_advance;
  logic    out_valid;
  result_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_input       <= 1'b0;
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
      cfg.long_event_enable  <= 1'b0;
      cfg.click_event_enable <= 1'b0;
      cfg.click_tag          <= '0;
      cfg.long_tag           <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INVERT_INPUT:       cfg.invert_input       <= wr_data[0];
        REG_DEBOUNCE_TICKS:     cfg.debounce_ticks     <= wr_data[15:0];
        REG_LONG_PRESS_TICKS:   cfg.long_press_ticks   <= wr_data[15:0];
        REG_LONG_EVENT_ENABLE:  cfg.long_event_enable  <= wr_data[0];
        REG_CLICK_EVENT_ENABLE: cfg.click_event_enable <= wr_data[0];
        REG_CLICK_TAG:          cfg.click_tag          <= wr_data[7:0];
        REG_LONG_TAG:           cfg.long_tag           <= wr_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign s1_advance  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op        <= in_ch.op;
      s1_raw_level <= in_ch.raw_level;
      s1_new_value <= in_ch.new_value;
    end
  end

  bdcl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (s1_advance),
    .op        (s1_op),
    .raw_level (s1_raw_level),
    .new_value (s1_new_value),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_word <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_kind   = out_word.event_kind;
  assign out_ch.event_tag    = out_word.event_tag;
  assign out_ch.is_pressed   = out_word.is_pressed;
  assign out_ch.toggle_value = out_word.toggle_value;

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.event_kind == EV_NONE || out_word.event_kind == EV_CLICK ||
                   out_word.event_kind == EV_LONG))
    else $error("illegal event kind");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.event_kind == EV_NONE) |-> out_word.event_tag == '0)
    else $error("tag set without event");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> s1_valid && $stable(s1_op) && $stable(s1_raw_level))
    else $error("stalled input stage lost its word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(out_word))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== rtl/bdcl_core.sv =====
// Debounce, hold timer and toggle state with next-state and event logic.
`default_nettype none
module bdcl_core
  import bdcl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step_en,
  input  wire logic    op,
  input  wire logic    raw_level,
  input  wire logic    new_value,
  input  wire cfg_t    cfg,
  output result_t      res
);

  logic                   last_level;
  logic [COUNT_WIDTH-1:0] stable_count;
  logic                   pressed_state;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic                   hold_timing;
  logic                   toggle_state;

  logic                   last_level_next;
  logic [COUNT_WIDTH-1:0] stable_count_next;
  logic                   pressed_state_next;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic                   hold_timing_next;
  logic                   toggle_state_next;

  logic                   level;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   settled;
  logic                   press;
  logic                   release_ev;
  logic                   long_ev;
  logic                   click_ev;

  always_comb begin
    level    = raw_level ^ cfg.invert_input;
    hold_inc = hold_count;
    if (hold_timing && hold_count != CNT_MAX) begin
      hold_inc = hold_count + 1'b1;
    end

    if (level != last_level) begin
      stable_count_next = '0;
    end else if (stable_count != CNT_MAX) begin
      stable_count_next = stable_count + 1'b1;
    end else begin
      stable_count_next = stable_count;
    end

    settled = CMP_WIDTH'(stable_count_next) > CMP_WIDTH'(cfg.debounce_ticks);
    press      = settled && level && !pressed_state;
    release_ev = settled && !level && pressed_state;
    long_ev    = settled && pressed_state && hold_timing && cfg.long_event_enable &&
                 (CMP_WIDTH'(hold_inc) > CMP_WIDTH'(cfg.long_press_ticks));
    // A long event clears the hold timer, which cancels the click.
    click_ev   = release_ev && hold_timing && !long_ev && cfg.click_event_enable;

    last_level_next    = last_level;
    pressed_state_next = pressed_state;
    hold_timing_next   = hold_timing;
    toggle_state_next  = toggle_state;
    res.event_kind     = EV_NONE;
    res.event_tag      = '0;

    if (op == OP_WRITE_TOGGLE) begin
      stable_count_next = stable_count;
      hold_count_next   = hold_count;
      toggle_state_next = new_value;
    end else begin
      last_level_next = level;
      hold_count_next = press ? '0 : hold_inc;
      if (press) begin
        hold_timing_next = 1'b1;
      end else if (long_ev) begin
        hold_timing_next = 1'b0;
      end
      if (release_ev) begin
        toggle_state_next = ~toggle_state;
      end
      if (settled) begin
        pressed_state_next = level;
      end
      if (long_ev) begin
        res.event_kind = EV_LONG;
        res.event_tag  = cfg.long_tag;
      end else if (click_ev) begin
        res.event_kind = EV_CLICK;
        res.event_tag  = cfg.click_tag;
      end
    end

    res.is_pressed   = pressed_state_next;
    res.toggle_value = toggle_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      stable_count  <= '0;
      pressed_state <= 1'b0;
      hold_count    <= '0;
      hold_timing   <= 1'b0;
      toggle_state  <= 1'b0;
    end else if (step_en) begin
      last_level    <= last_level_next;
      stable_count  <= stable_count_next;
      pressed_state <= pressed_state_next;
      hold_count    <= hold_count_next;
      hold_timing   <= hold_timing_next;
      toggle_state  <= toggle_state_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/button_debounce_click_longpress_tb.sv =====
// Testbench for the button debouncer: predicts click, long-press and toggle results per word.
`timescale 1ns / 1ps
module button_debounce_click_longpress_tb;
  import bdcl_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  class bdcl_scoreboard;
    cfg_t                   cfg;
    logic                   last_lvl;
    logic [COUNT_WIDTH-1:0] stable_cnt;
    logic [COUNT_WIDTH-1:0] hold_cnt;
    logic                   pressed;
    logic                   hold_on;
    logic                   toggle;
    result_t                pending_q[$];
    int                     errors;

    function new();
      cfg                  = '0;
      cfg.debounce_ticks   = DEBOUNCE_RESET;
      cfg.long_press_ticks = LONG_PRESS_RESET;
      last_lvl   = 1'b0;
      stable_cnt = '0;
      hold_cnt   = '0;
      pressed    = 1'b0;
      hold_on    = 1'b0;
      toggle     = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_INVERT_INPUT:       cfg.invert_input       = data[0];
        REG_DEBOUNCE_TICKS:     cfg.debounce_ticks     = data[15:0];
        REG_LONG_PRESS_TICKS:   cfg.long_press_ticks   = data[15:0];
        REG_LONG_EVENT_ENABLE:  cfg.long_event_enable  = data[0];
        REG_CLICK_EVENT_ENABLE: cfg.click_event_enable = data[0];
        REG_CLICK_TAG:          cfg.click_tag          = data[7:0];
        REG_LONG_TAG:           cfg.long_tag           = data[7:0];
        default: ;
      endcase
    endfunction

    // Advance the debounce state by one accepted word and queue the result it must produce.
    function void note_word(logic op, logic raw, logic nv);
      result_t want;
      logic    lvl;
      want = '0;
      if (op == OP_WRITE_TOGGLE) begin
        toggle = nv;
      end else begin
        lvl = raw ^ cfg.invert_input;
        if (lvl != last_lvl) stable_cnt = '0;
        else if (stable_cnt != CNT_MAX) stable_cnt = stable_cnt + 1'b1;
        if (hold_on && hold_cnt != CNT_MAX) hold_cnt = hold_cnt + 1'b1;
        if (stable_cnt > cfg.debounce_ticks) begin
          if (lvl && !pressed) begin
            hold_cnt = '0;
            hold_on  = 1'b1;
          end
          if (pressed && hold_on && cfg.long_event_enable &&
              hold_cnt > cfg.long_press_ticks) begin
            want.event_kind = EV_LONG;
            want.event_tag  = cfg.long_tag;
            hold_on         = 1'b0;
          end
          // a long event in the same tick has already dropped the hold timer, so no click
          if (!lvl && pressed) begin
            toggle = ~toggle;
            if (hold_on && cfg.click_event_enable) begin
              want.event_kind = EV_CLICK;
              want.event_tag  = cfg.click_tag;
            end
          end
          pressed = lvl;
        end
        last_lvl = lvl;
      end
      want.is_pressed   = pressed;
      want.toggle_value = toggle;
      pending_q.push_back(want);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: kind %0d tag %h pressed %b toggle %b",
                   got.event_kind, got.event_tag, got.is_pressed, got.toggle_value);
        return;
      end
      want = pending_q.pop_front();
      if (got.event_kind !== want.event_kind || got.event_tag !== want.event_tag ||
          got.is_pressed !== want.is_pressed || got.toggle_value !== want.toggle_value) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch: expected kind %0d tag %h pressed %b toggle %b, ",
                 want.event_kind, want.event_tag, want.is_pressed, want.toggle_value);
          $display("got kind %0d tag %h pressed %b toggle %b",
                   got.event_kind, got.event_tag, got.is_pressed, got.toggle_value);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       wr_en;
  logic [CFG_INDEX_WIDTH-1:0] wr_index;
  logic [CFG_DATA_WIDTH-1:0]  wr_data;

  bdcl_in_if  in_ch ();
  bdcl_out_if out_ch ();

  button_debounce_click_longpress dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  bdcl_scoreboard sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             words_sent;
  logic           episode_level;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.event_kind, out_ch.event_tag, out_ch.is_pressed,
                     out_ch.toggle_value});
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic op, input logic raw, input logic nv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.raw_level = raw;
    in_ch.new_value = nv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(op, raw, nv);
    words_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every queued result has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic random_config();
    int deb;
    deb = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
    write_reg(REG_INVERT_INPUT, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_DEBOUNCE_TICKS, 16'(deb));
    write_reg(REG_LONG_PRESS_TICKS, 16'($urandom_range(24)));
    write_reg(REG_LONG_EVENT_ENABLE, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_CLICK_EVENT_ENABLE, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_CLICK_TAG, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_LONG_TAG, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
  endtask

  // One press or release with contact bounce in front, or a short burst of noise.
  task automatic run_episode();
    int span;
    int n;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(3)) send_word(OP_TICK, 1'($urandom_range(1)),
                                           1'($urandom_range(1)));
      span = int'(sb.cfg.debounce_ticks) + int'(sb.cfg.long_press_ticks) + 6;
      n    = $urandom_range(1, span);
      repeat (n) begin
        if ($urandom_range(19) == 0)
          send_word(OP_WRITE_TOGGLE, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_word(OP_TICK, episode_level, 1'($urandom_range(1)));
      end
      episode_level = ~episode_level;
    end
  endtask

  // Run against the largest thresholds, which a short run never exceeds.
  task automatic threshold_sweep();
    drain();
    write_reg(REG_INVERT_INPUT, 16'd1);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_LONG_PRESS_TICKS, 16'hFFFF);
    write_reg(REG_LONG_EVENT_ENABLE, 16'd1);
    write_reg(REG_CLICK_EVENT_ENABLE, 16'd1);
    repeat (2) send_word(OP_TICK, 1'b1, 1'b0);
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 16'hFFFF);
    repeat (40) send_word(OP_TICK, 1'b0, 1'b0);
    drain();
    write_reg(REG_LONG_PRESS_TICKS, 16'hFFFE);
    send_word(OP_TICK, 1'b0, 1'b0);
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    repeat (2) send_word(OP_TICK, 1'b1, 1'b0);
  endtask

  initial begin
    int start;
    sb              = new();
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = '0;
    wr_data         = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_TICK;
    in_ch.raw_level = 1'b0;
    in_ch.new_value = 1'b0;
    send_idle_pct   = 21;
    recv_idle_pct   = 62;
    words_sent      = 0;
    episode_level   = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // defaults straight out of reset
    send_word(OP_TICK, 1'b1, 1'b0);
    send_word(OP_TICK, 1'b1, 1'b0);
    send_word(OP_WRITE_TOGGLE, 1'b0, 1'b1);
    send_word(OP_WRITE_TOGGLE, 1'b1, 1'b0);
    drain();
    write_reg(REG_INVERT_INPUT, 16'hFFFE);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_LONG_PRESS_TICKS, 16'd2);
    write_reg(REG_LONG_EVENT_ENABLE, 16'h0001);
    write_reg(REG_CLICK_EVENT_ENABLE, 16'hFFFF);
    write_reg(REG_CLICK_TAG, 16'h12FF);
    write_reg(REG_LONG_TAG, 16'hFF00);
    write_reg(REG_UNUSED, 16'hFFFF);
    // settle released, short press with click
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b1, 1'b0);
    send_word(OP_TICK, 1'b1, 1'b0);
    send_word(OP_WRITE_TOGGLE, 1'b1, 1'b1);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    // long press, then a release that clicks nothing
    repeat (5) send_word(OP_TICK, 1'b1, 1'b1);
    send_word(OP_WRITE_TOGGLE, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b1);
    send_word(OP_TICK, 1'b0, 1'b1);
    // long event lands on the release tick
    repeat (3) send_word(OP_TICK, 1'b1, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 21 : (m == 1) ? 62 : 0;
      recv_idle_pct = (m == 0) ? 62 : (m == 1) ? 21 : 0;
      for (int s = 0; s < 3; s++) begin
        drain();
        random_config();
        start = words_sent;
        while (words_sent - start < 230) begin
          run_episode();
          if ($urandom_range(39) == 0) drain();
        end
      end
    end

    threshold_sweep();
    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bdcl_pkg.sv
rtl/bdcl_if.sv
rtl/bdcl_core.sv
rtl/button_debounce_click_longpress.sv
dv/button_debounce_click_longpress_tb.sv
